// ----- hw/rtl/lpvf_pkg.sv -----
// lpvf_pkg: shared types and constants of the lidar point validity filter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lpvf_pkg;

  localparam int COORD_W = 28;
  localparam int BYTE_W  = 8;
  localparam int TIME_W  = 32;
  localparam int DECIM_W = 7;
  localparam int PHASE_W = 6;
  localparam int BLIND_W = 56;
  localparam int SQ_W    = 55;   // |coord| <= 2^27, square fits 55 bits
  localparam int CFG_IDX_W = 2;

  localparam logic [DECIM_W-1:0] DECIM_MAX = 7'd64;

  localparam logic [BYTE_W-1:0] TAG_CLASS_MASK   = 8'h30;
  localparam logic [BYTE_W-1:0] TAG_CLASS_FIRST  = 8'h00;
  localparam logic [BYTE_W-1:0] TAG_CLASS_SECOND = 8'h10;

  localparam logic [BYTE_W-1:0]  LINES_RST = 8'd6;
  localparam logic [DECIM_W-1:0] DECIM_RST = 7'd1;
  localparam logic [BLIND_W-1:0] BLIND_RST = 56'd42949673;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINES_IN_USE = 2'd0,
    CFG_DECIMATION   = 2'd1,
    CFG_BLIND_SQ     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic signed [COORD_W-1:0] z_pos;
    logic [BYTE_W-1:0]         reflectivity;
    logic [BYTE_W-1:0]         tag_bits;
    logic [BYTE_W-1:0]         line_number;
    logic [TIME_W-1:0]         offset_ns;
    logic                      scan_start;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [BYTE_W-1:0]         out_intensity;
    logic [TIME_W-1:0]         out_time_ns;
  } out_word_t;

  // Candidate point between the gating stage and the range check.
  typedef struct packed {
    out_word_t       word;
    logic [SQ_W-1:0] sq_x;
    logic [SQ_W-1:0] sq_y;
    logic [SQ_W-1:0] sq_z;
  } cand_t;

endpackage

// ----- hw/rtl/lidar_point_validity_filter_core.sv -----
// lidar_point_validity_filter_core: top level of the lidar point filter.
// Holds the configuration registers; uses lpvf_pkg, lpvf_gate and lpvf_range.
`timescale 1ns / 1ps

// The filter takes one lidar point word per clock when not stalled and passes
// on at most one point word for it, via the candidate and result registers.
// The first point of a scan (scan_start set) is always dropped. A later point
// is kept when its line is below lines_in_use, tag bits 5:4 are 00 or 01, its
// in-scan index is a multiple of decimation (0 counts as 1, values above 64
// as 64), some coordinate differs from the point stored for the previous
// index (zero if that index stored nothing) and x^2+y^2+z^2 is strictly above
// blind_sq (units 2^-32 m^2). Sustained rate is one word per cycle while the
// output is free: the scan phase and previous-point registers update from the
// input register, the three 28x28 squares are registered, and the sum and
// compare sit in front of the result register. Three word stages (input,
// candidate, result) each advance when the one after is free, so bubbles left
// by dropped points close up and a new word is taken while a result waits.
// Configuration is written on the plain port and should only change while
// the pipeline is empty; writes to an unknown index are ignored.

module lidar_point_validity_filter_core import lpvf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // point input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [BLIND_W-1:0]    cfg_wdata_i
);

  logic [BYTE_W-1:0]  lines_q;
  logic [DECIM_W-1:0] decim_q;
  logic [BLIND_W-1:0] blind_q;

  logic  cand_valid, cand_ready;
  cand_t cand;

  // Configuration registers, truncated to their widths.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q <= LINES_RST;
      decim_q <= DECIM_RST;
      blind_q <= BLIND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LINES_IN_USE: lines_q <= cfg_wdata_i[BYTE_W-1:0];
        CFG_DECIMATION:   decim_q <= cfg_wdata_i[DECIM_W-1:0];
        CFG_BLIND_SQ:     blind_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Gating: scan phase, previous point, squares.
  lpvf_gate u_gate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .lines_i      (lines_q),
    .decim_i      (decim_q),
    .cand_valid_o (cand_valid),
    .cand_o       (cand),
    .cand_ready_i (cand_ready)
  );

  // Blind-zone check and result register.
  lpvf_range u_range (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cand_valid_i (cand_valid),
    .cand_i       (cand),
    .cand_ready_o (cand_ready),
    .blind_sq_i   (blind_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

  // With the output draining, every stage advances, so input never stalls.
  a_no_stall_when_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  // A kept point lies strictly outside the blind zone, so it cannot be origin.
  a_kept_not_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.out_x != '0 || out_word_o.out_y != '0 ||
                     out_word_o.out_z != '0))
    else $error("point at origin passed the blind-zone check");

  // A result register that is empty or drained cannot stall the input side.
  a_empty_out_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

endmodule

// ----- hw/rtl/lpvf_gate.sv -----
// lpvf_gate: input register, scan/decimation state and per-point gating.
// Also squares the coordinates for the range stage. Depends on lpvf_pkg.
`timescale 1ns / 1ps

module lpvf_gate import lpvf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  input  logic [BYTE_W-1:0]   lines_i,
  input  logic [DECIM_W-1:0]  decim_i,
  output logic                cand_valid_o,
  output cand_t               cand_o,
  input  logic                cand_ready_i
);

  logic                  s1_v_q;
  in_word_t              in_q;
  logic                  cand_v_q;
  cand_t                 cand_q, cand_d;
  logic                  s1_adv, s2_adv, fire, keep;

  logic [COORD_W-1:0]    prev_x_q, prev_y_q, prev_z_q;
  logic [COORD_W-1:0]    prev_x_d, prev_y_d, prev_z_d;
  logic [PHASE_W-1:0]    phase_q, phase_d, phase_next;
  logic [DECIM_W-1:0]    dec_eff, phase_inc;
  logic                  line_ok, tag_ok, stored, differs;
  logic signed [2*COORD_W-1:0] sqf_x, sqf_y, sqf_z;

  assign s2_adv     = !cand_v_q || cand_ready_i;
  assign s1_adv     = !s1_v_q || s2_adv;
  assign fire       = s1_v_q && s2_adv;
  assign in_stall_o = !s1_adv;

  // Zero decimation acts as one, large values saturate.
  always_comb begin
    priority if (decim_i == '0) begin
      dec_eff = DECIM_W'(1);
    end else if (decim_i > DECIM_MAX) begin
      dec_eff = DECIM_MAX;
    end else begin
      dec_eff = decim_i;
    end
  end

  assign phase_inc  = {1'b0, phase_q} + DECIM_W'(1);
  assign phase_next = (phase_inc >= dec_eff) ? '0 : phase_inc[PHASE_W-1:0];

  assign line_ok = in_q.line_number < lines_i;
  assign tag_ok  = ((in_q.tag_bits & TAG_CLASS_MASK) == TAG_CLASS_FIRST) ||
                   ((in_q.tag_bits & TAG_CLASS_MASK) == TAG_CLASS_SECOND);
  assign stored  = line_ok && tag_ok && (phase_q == '0);
  assign differs = (in_q.x_pos != prev_x_q) || (in_q.y_pos != prev_y_q) ||
                   (in_q.z_pos != prev_z_q);

  always_comb begin
    prev_x_d = prev_x_q;
    prev_y_d = prev_y_q;
    prev_z_d = prev_z_q;
    phase_d  = phase_q;
    keep     = 1'b0;
    if (in_q.scan_start) begin
      prev_x_d = '0;
      prev_y_d = '0;
      prev_z_d = '0;
      phase_d  = (dec_eff > DECIM_W'(1)) ? PHASE_W'(1) : '0;
    end else begin
      phase_d = phase_next;
      if (stored) begin
        prev_x_d = in_q.x_pos;
        prev_y_d = in_q.y_pos;
        prev_z_d = in_q.z_pos;
        keep     = differs;
      end else begin
        prev_x_d = '0;
        prev_y_d = '0;
        prev_z_d = '0;
      end
    end
  end

  // Squares are non-negative and below 2^55.
  assign sqf_x = in_q.x_pos * in_q.x_pos;
  assign sqf_y = in_q.y_pos * in_q.y_pos;
  assign sqf_z = in_q.z_pos * in_q.z_pos;

  always_comb begin
    cand_d.word.out_x         = in_q.x_pos;
    cand_d.word.out_y         = in_q.y_pos;
    cand_d.word.out_z         = in_q.z_pos;
    cand_d.word.out_intensity = in_q.reflectivity;
    cand_d.word.out_time_ns   = in_q.offset_ns;
    cand_d.sq_x               = sqf_x[SQ_W-1:0];
    cand_d.sq_y               = sqf_y[SQ_W-1:0];
    cand_d.sq_z               = sqf_z[SQ_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      cand_v_q <= 1'b0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      prev_z_q <= '0;
      phase_q  <= '0;
    end else begin
      if (s1_adv) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_adv) begin
        cand_v_q <= fire && keep;
      end
      if (fire) begin
        prev_x_q <= prev_x_d;
        prev_y_q <= prev_y_d;
        prev_z_q <= prev_z_d;
        phase_q  <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_adv) begin
      in_q <= in_word_i;
    end
    if (fire && keep) begin
      cand_q <= cand_d;
    end
  end

  assign cand_valid_o = cand_v_q;
  assign cand_o       = cand_q;

endmodule

// ----- hw/rtl/lpvf_range.sv -----
// lpvf_range: squared-range check against the blind zone and result register.
// Depends on lpvf_pkg.
`timescale 1ns / 1ps

module lpvf_range import lpvf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cand_valid_i,
  input  cand_t               cand_i,
  output logic                cand_ready_o,
  input  logic [BLIND_W-1:0]  blind_sq_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o
);

  logic               out_v_q;
  out_word_t          out_word_q;
  logic               out_adv, outside;
  logic [BLIND_W-1:0] range_sq;

  // Sum of three squares is at most 3 * 2^54, no overflow in 56 bits.
  assign range_sq = {1'b0, cand_i.sq_x} + {1'b0, cand_i.sq_y} + {1'b0, cand_i.sq_z};
  assign outside  = range_sq > blind_sq_i;

  assign out_adv      = !out_v_q || !out_stall_i;
  assign cand_ready_o = out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= cand_valid_i && outside;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && cand_valid_i && outside) begin
      out_word_q <= cand_i.word;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_word_q;

endmodule
